@@ src/mandelbrot_escape_time_macros.svh @@
// assertion macros for the mandelbrot escape-time block
// expects clk and rst_n in the scope where a macro is used
`ifndef MANDELBROT_ESCAPE_TIME_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_MACROS_SVH

// same-cycle implication, off while in reset
`define MBE_CHECK(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mbe check failed");

// next-cycle implication, off while in reset
`define MBE_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mbe next-cycle check failed");

`endif

@@ src/mbe_pkg.sv @@
// shared constants, types and helpers for the mandelbrot escape-time block
// no dependencies
package mbe_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 28;
  localparam int ITER_BITS  = 16;
  localparam int FIX_W      = 32;
  localparam int WIDE_W     = 2 * FIX_W;
  localparam int ROWS_W     = 13;
  localparam int PIDX_W     = 24;
  localparam int ESC_SH     = 2 * FRAC_BITS + 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_W       = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_W      = ((ITER_BITS + PIDX_W + 7) / 8) * 8;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef logic [COORD_BITS-1:0]   coord_t;
  typedef logic signed [FIX_W-1:0] fix_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic [ITER_BITS-1:0]    iter_t;
  typedef logic [ROWS_W-1:0]       rows_t;
  typedef logic [PIDX_W-1:0]       pidx_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_LOW     = 3'd0,
    REG_Y_LOW     = 3'd1,
    REG_X_STEP    = 3'd2,
    REG_Y_STEP    = 3'd3,
    REG_MAX_ITERS = 3'd4,
    REG_ROWS      = 3'd5
  } cfg_reg_t;

  localparam fix_t  X_LOW_RST     = 32'shE000_0000;
  localparam fix_t  Y_LOW_RST     = 32'shF000_0000;
  localparam fix_t  X_STEP_RST    = 32'sh0004_0000;
  localparam fix_t  Y_STEP_RST    = 32'sh0004_0000;
  localparam iter_t MAX_ITERS_RST = 16'd256;
  localparam rows_t ROWS_RST      = 13'd1024;

  typedef struct packed {
    fix_t  x_low;
    fix_t  y_low;
    fix_t  x_step;
    fix_t  y_step;
    iter_t max_iters;
    rows_t rows;
  } cfg_t;

  // one mapped pixel handed from front to back
  typedef struct packed {
    fix_t  cre;
    fix_t  cim;
    pidx_t idx;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic fix_t sat_fix(input wide_t v);
    wide_t hi;
    wide_t lo;
    hi = {{(WIDE_W - FIX_W + 1){1'b0}}, {(FIX_W - 1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      sat_fix = hi[FIX_W-1:0];
    end else if (v < lo) begin
      sat_fix = lo[FIX_W-1:0];
    end else begin
      sat_fix = v[FIX_W-1:0];
    end
  endfunction

endpackage

@@ src/mbe_fifo.sv @@
// short job queue between the mapping front and the iteration back
// depends on mbe_pkg
module mbe_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mbe_pkg::job_t       wdata,
  input  logic                pop,
  output mbe_pkg::job_t       rdata,
  output mbe_pkg::fifo_stat_t stat
);
  import mbe_pkg::*;

  job_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, wp_nxt;
  logic [FIFO_AW-1:0] rp_r, rp_nxt;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == FIFO_CW'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rdata      = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

@@ src/mbe_front.sv @@
// input side: takes pixel words and maps them to a point c and a store index
// two register stages, then a push into the job queue; depends on mbe_pkg
module mbe_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mbe_pkg::cfg_t              cfg,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [mbe_pkg::IN_W-1:0]   in_tdata,
  input  mbe_pkg::fifo_stat_t        q_stat,
  output logic                       q_push,
  output mbe_pkg::job_t              q_data
);
  import mbe_pkg::*;

  localparam int PX_W = COORD_BITS + 1 + FIX_W;
  localparam int IP_W = COORD_BITS + ROWS_W;

  logic                   s1_v_r, s1_v_nxt;
  logic                   s2_v_r, s2_v_nxt;
  logic signed [PX_W-1:0] px_r, px_nxt;
  logic signed [PX_W-1:0] py_r, py_nxt;
  logic [IP_W-1:0]        ip_r, ip_nxt;
  coord_t                 row1_r;
  job_t                   job_r, job_nxt;

  coord_t                 col;
  coord_t                 row;
  logic                   accept;
  logic                   s2_take;
  logic                   s1_move;
  wide_t                  cre_sum;
  wide_t                  cim_sum;
  logic [IP_W-1:0]        idx_sum;

  assign col     = in_tdata[COORD_BITS-1:0];
  assign row     = in_tdata[2*COORD_BITS-1:COORD_BITS];
  assign q_push  = s2_v_r && !q_stat.full;
  assign q_data  = job_r;
  assign s2_take = !s2_v_r || q_push;
  assign s1_move = s1_v_r && s2_take;
  assign in_tready = !s1_v_r || s2_take;
  assign accept  = in_tvalid && in_tready;

  always_comb begin
    s1_v_nxt = accept || (s1_v_r && !s2_take);
    s2_v_nxt = s1_move || (s2_v_r && !q_push);

    // stage one: the three products
    px_nxt = $signed({1'b0, col}) * cfg.x_step;
    py_nxt = $signed({1'b0, row}) * cfg.y_step;
    ip_nxt = IP_W'(col) * IP_W'(cfg.rows);

    // stage two: offsets, saturation and index wrap
    cre_sum = px_r;
    cre_sum = cre_sum + cfg.x_low;
    cim_sum = py_r;
    cim_sum = cim_sum + cfg.y_low;
    idx_sum = ip_r + IP_W'(row1_r);
    job_nxt.cre = sat_fix(cre_sum);
    job_nxt.cim = sat_fix(cim_sum);
    job_nxt.idx = idx_sum[PIDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      ip_r   <= ip_nxt;
      row1_r <= row;
    end
    if (s1_move) begin
      job_r <= job_nxt;
    end
  end

endmodule

@@ src/mbe_back.sv @@
// iteration side: runs z = z^2 + c for one job at a time and holds the result
// each iteration is S_MUL (squares), then S_TEST (test and update); depends on mbe_pkg
module mbe_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mbe_pkg::iter_t             max_iters,
  input  mbe_pkg::job_t              q_data,
  input  mbe_pkg::fifo_stat_t        q_stat,
  output logic                       q_pop,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [mbe_pkg::OUT_W-1:0]  out_tdata
);
  import mbe_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_TEST = 4'b0100,
    S_HOLD = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  fix_t   cre_r, cre_nxt;
  fix_t   cim_r, cim_nxt;
  pidx_t  idx_r, idx_nxt;
  fix_t   zre_r, zre_nxt;
  fix_t   zim_r, zim_nxt;
  iter_t  cnt_r, cnt_nxt;
  wide_t  sq_re_r, sq_re_nxt;
  wide_t  sq_im_r, sq_im_nxt;
  wide_t  xy_r, xy_nxt;
  logic   out_v_r, out_v_nxt;
  iter_t  out_cnt_r, out_cnt_nxt;
  pidx_t  out_idx_r, out_idx_nxt;

  logic [WIDE_W-1:0] mag;
  logic              esc;
  wide_t             re_acc;
  wide_t             im_acc;

  assign q_pop      = (state_r == S_IDLE) && !q_stat.empty;
  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_W'({out_idx_r, out_cnt_r});

  always_comb begin
    state_nxt   = state_r;
    cre_nxt     = cre_r;
    cim_nxt     = cim_r;
    idx_nxt     = idx_r;
    zre_nxt     = zre_r;
    zim_nxt     = zim_r;
    cnt_nxt     = cnt_r;
    sq_re_nxt   = sq_re_r;
    sq_im_nxt   = sq_im_r;
    xy_nxt      = xy_r;
    out_v_nxt   = out_v_r && !out_tready;
    out_cnt_nxt = out_cnt_r;
    out_idx_nxt = out_idx_r;

    // magnitude test, exact sum of squares against 4
    mag    = $unsigned(sq_re_r) + $unsigned(sq_im_r);
    esc    = (mag >> ESC_SH) != '0;
    // floor shifts back to the fixed-point scale, then add c
    re_acc = (sq_re_r - sq_im_r) >>> FRAC_BITS;
    re_acc = re_acc + cre_r;
    im_acc = xy_r >>> (FRAC_BITS - 1);
    im_acc = im_acc + cim_r;

    case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          cre_nxt   = q_data.cre;
          cim_nxt   = q_data.cim;
          idx_nxt   = q_data.idx;
          zre_nxt   = '0;
          zim_nxt   = '0;
          cnt_nxt   = ITER_BITS'(1);
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        sq_re_nxt = zre_r * zre_r;
        sq_im_nxt = zim_r * zim_r;
        xy_nxt    = zre_r * zim_r;
        state_nxt = S_TEST;
      end
      S_TEST: begin
        if ((cnt_r >= max_iters) || esc) begin
          state_nxt = S_HOLD;
        end else begin
          zre_nxt   = sat_fix(re_acc);
          zim_nxt   = sat_fix(im_acc);
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_HOLD: begin
        if (!out_v_r || out_tready) begin
          out_v_nxt   = 1'b1;
          out_cnt_nxt = cnt_r;
          out_idx_nxt = idx_r;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cre_r     <= cre_nxt;
    cim_r     <= cim_nxt;
    idx_r     <= idx_nxt;
    zre_r     <= zre_nxt;
    zim_r     <= zim_nxt;
    cnt_r     <= cnt_nxt;
    sq_re_r   <= sq_re_nxt;
    sq_im_r   <= sq_im_nxt;
    xy_r      <= xy_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_idx_r <= out_idx_nxt;
  end

endmodule

@@ src/mandelbrot_escape_time.sv @@
// mandelbrot escape-time block: config registers, front, job queue, back
// depends on mbe_pkg, mbe_front, mbe_fifo, mbe_back and the assertion macros
//
// usage:
//   cfg_*   register writes (index 0..5: x_low, y_low, x_step, y_step,
//           max_iters, rows), always ready; write only while the block is idle
//   in_*    one word per pixel: pixel_col in [11:0], pixel_row in [23:12]
//   out_*   one word per pixel: iteration_count in [15:0], pixel_index
//           in [39:16]; results leave in input order
// flow: the front maps a pixel through two register stages and queues it in a
//   job queue of two entries; the back iterates one pixel at a time, a squaring
//   step and a test/update step per iteration, so the iteration loop sets the
//   rate at which pixels complete
// reset: synchronous, active low; registers return to their reset values,
//   queue and result register are emptied
// stall: a held result stays in the output register while the back works on the
//   next queued pixel; the front keeps accepting until the queue and both of its stages are full
`include "mandelbrot_escape_time_macros.svh"

module mandelbrot_escape_time (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbe_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // pixel_col [11:0], pixel_row [23:12]
  input  logic [mbe_pkg::IN_W-1:0]       in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // iteration_count [15:0], pixel_index [39:16]
  output logic [mbe_pkg::OUT_W-1:0]      out_tdata
);
  import mbe_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic       cfg_wr;
  logic       q_push;
  logic       q_pop;
  job_t       q_wdata;
  job_t       q_rdata;
  fifo_stat_t q_stat;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (cfg_reg_t'(cfg_index))
        REG_X_LOW:     cfg_nxt.x_low     = cfg_data[FIX_W-1:0];
        REG_Y_LOW:     cfg_nxt.y_low     = cfg_data[FIX_W-1:0];
        REG_X_STEP:    cfg_nxt.x_step    = cfg_data[FIX_W-1:0];
        REG_Y_STEP:    cfg_nxt.y_step    = cfg_data[FIX_W-1:0];
        REG_MAX_ITERS: cfg_nxt.max_iters = cfg_data[ITER_BITS-1:0];
        REG_ROWS:      cfg_nxt.rows      = cfg_data[ROWS_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_low     <= X_LOW_RST;
      cfg_r.y_low     <= Y_LOW_RST;
      cfg_r.x_step    <= X_STEP_RST;
      cfg_r.y_step    <= Y_STEP_RST;
      cfg_r.max_iters <= MAX_ITERS_RST;
      cfg_r.rows      <= ROWS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mbe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  mbe_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  mbe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .max_iters  (cfg_r.max_iters),
    .q_data     (q_rdata),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  `MBE_CHECK(a_push_has_room, q_push, !q_stat.full)
  `MBE_CHECK(a_pop_has_word, q_pop, !q_stat.empty)
  `MBE_CHECK(a_count_nonzero, out_tvalid, out_tdata[ITER_BITS-1:0] != '0)
  `MBE_CHECK(a_count_in_limit, out_tvalid && (cfg_r.max_iters > ITER_BITS'(1)), out_tdata[ITER_BITS-1:0] <= cfg_r.max_iters)
  `MBE_CHECK_NEXT(a_limit_written, cfg_wr && (cfg_index == REG_MAX_ITERS), cfg_r.max_iters == $past(cfg_data[ITER_BITS-1:0]))

endmodule
